// File: hdl/fiws_pkg.sv
// Package with types, codes and constants of the frame interval window statistics block.
`default_nettype none
package fiws_pkg;

  localparam int DEFAULT_WINDOW_DEPTH = 4096;
  localparam int IV_W = 24;
  localparam int TS_W = 63;
  localparam int Q_W  = 17;
  localparam int FC_W = 13;

  localparam logic [IV_W-1:0] MAX_INTERVAL_US = 24'd10000000;
  localparam logic [Q_W-1:0]  Q_ONE           = 17'h10000;
  localparam logic [Q_W-1:0]  Q_HALF          = 17'h08000;
  localparam logic [12:0]     RESET_CAPACITY  = 13'd4096;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_TRIM  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_WINDOW   = 1'b1;

  localparam logic [1:0] SEL_MEDIAN   = 2'd0;
  localparam logic [1:0] SEL_QUANTILE = 2'd1;
  localparam logic [1:0] SEL_MIN      = 2'd2;
  localparam logic [1:0] SEL_MAX      = 2'd3;

  typedef struct packed {
    logic [1:0]      mode;
    logic [IV_W-1:0] interval_us;
    logic [TS_W-1:0] timestamp_ticks;
    logic [Q_W-1:0]  quantile;
  } fiws_in_t;

  typedef struct packed {
    logic            accepted;
    logic [FC_W-1:0] frame_count;
    logic [IV_W-1:0] quantile_us;
    logic [IV_W-1:0] median_us;
    logic [IV_W-1:0] min_us;
    logic [IV_W-1:0] max_us;
    logic [IV_W-1:0] average_us;
    logic [FC_W-1:0] stutter_count;
    logic [TS_W-1:0] span_ticks;
  } fiws_out_t;

  typedef struct packed {
    logic [IV_W-1:0] iv;
    logic [TS_W-1:0] ts;
  } fiws_entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_UPD,
    ST_PUSH,
    ST_TR_RD,
    ST_TR_CHK,
    ST_Q_RANK,
    ST_SEL_INIT,
    ST_SEL_SCAN,
    ST_SEL_DEC,
    ST_STUT_SCAN,
    ST_DIV,
    ST_DIV_WAIT,
    ST_SPAN_A,
    ST_SPAN_B,
    ST_SPAN_C,
    ST_FINISH
  } fiws_state_t;

endpackage
`default_nettype wire

// File: hdl/fiws_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module fiws_divider import fiws_pkg::*; #(
  parameter int SW = 37,
  parameter int CW = 13
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [SW-1:0] dividend,
  input  wire logic [CW-1:0] divisor,
  output logic               done,
  output logic [SW-1:0]      quotient
);

  localparam int NW = $clog2(SW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW:0]   rem_r, rem_nxt;
  logic [SW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] dsr_r, dsr_nxt;
  logic [CW:0]   rem_sh;
  logic          ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    rem_sh   = {rem_r[CW-1:0], quo_r[SW-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = NW'(SW);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sh - {1'b0, dsr_r} : rem_sh;
      quo_nxt = {quo_r[SW-2:0], ge};
      cnt_nxt = cnt_r - NW'(1);
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// File: hdl/frame_interval_window_stats.sv
// Top level of the frame interval window statistics block.
`default_nettype none
// Keeps a circular window of frame intervals with timestamps in one memory and walks it
// with a small sequencer; one item is handled at a time and in_stall stays high meanwhile.
// A push first evicts the oldest entries while the window is full, and it is rejected
// when its interval is zero or above MAX_INTERVAL_US. A trim evicts the oldest entries while
// their timestamps lie before its own timestamp less the trim window length, and it does
// nothing when trimming is off or the window is empty. A clear empties the window. A query
// on an empty window does no scan; otherwise the order statistics are found by a bitwise
// rank select that scans the window memory once per result bit, for each of the median,
// quantile, minimum and maximum, followed by one scan for the stutter count (with at least
// two entries), a bit-serial division for the mean and reads of the oldest and newest timestamps.
// After a capacity write that shrinks below the fill, the oldest entries are evicted
// one at a time before the next item is taken.
module frame_interval_window_stats import fiws_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire fiws_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output fiws_out_t      out_data,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = IV_W + CW;
  localparam int PW = Q_W + CW + 1;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(WINDOW_DEPTH)) s = s - (CW+1)'(WINDOW_DEPTH);
    return s[AW-1:0];
  endfunction

  fiws_entry_t mem [WINDOW_DEPTH];
  fiws_entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  fiws_entry_t   wr_data;

  fiws_state_t   state_r, state_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [CW-1:0] cap_r;
  logic [31:0]   wlen_r;
  fiws_in_t      in_r, in_nxt;
  logic          is_push_r, is_push_nxt;
  logic [63:0]   cut_r, cut_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [1:0]    sel_r, sel_nxt;
  logic [IV_W-1:0] res_r, res_nxt, mask_r, mask_nxt;
  logic [CW-1:0] k_r, k_nxt, cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic          rv_r, rv_nxt;
  logic [TS_W-1:0] t0_r, t0_nxt;
  fiws_out_t     acc_r, acc_nxt;
  fiws_out_t     out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          in_acc, cfg_wr, div_start, div_done;
  logic [SW-1:0] div_quo;
  logic [12:0]   cap_wr;
  logic [CW-1:0] cap_val, n_m1;
  logic [Q_W-1:0] q_sat;
  logic [CW+1:0] rank_q;
  logic [IV_W-1:0] bitsel, set_res;
  logic          match;
  logic [63:0]   diff;

  assign in_acc = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign in_stall = (state_r != ST_IDLE) || (count_r > cap_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_r) : wlen_r;

  assign cap_wr  = pwdata[12:0];
  assign cap_val = (cap_wr == 13'd0) ? CW'(1) :
                   (32'(cap_wr) > 32'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH) : CW'(cap_wr);
  assign n_m1   = count_r - CW'(1);
  assign q_sat  = (in_r.quantile > Q_ONE) ? Q_ONE : in_r.quantile;
  assign rank_q = prod_r[PW-1:16];
  assign bitsel = mask_r & ~(mask_r << 1);
  assign match  = ((rd_data.iv ^ res_r) & mask_r) == '0;
  assign diff   = {1'b0, rd_data.ts} - {1'b0, t0_r};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  fiws_divider #(.SW(SW), .CW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    in_nxt        = in_r;
    is_push_nxt   = is_push_r;
    cut_nxt       = cut_r;
    prod_nxt      = prod_r;
    sel_nxt       = sel_r;
    res_nxt       = res_r;
    mask_nxt      = mask_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    rv_nxt        = 1'b0;
    t0_nxt        = t0_r;
    acc_nxt       = acc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr       = oldest_r;
    wr_en         = 1'b0;
    wr_addr       = slot_of(oldest_r, count_r);
    wr_data       = {in_r.interval_us, in_r.timestamp_ticks};
    div_start     = 1'b0;
    set_res       = (k_r < cnt_r) ? res_r : (res_r | bitsel);

    case (state_r)
      ST_IDLE: begin
        if (count_r > cap_r) begin
          is_push_nxt = 1'b0;
          state_nxt   = ST_EV_RD;
        end else if (in_acc) begin
          in_nxt      = in_data;
          acc_nxt     = '0;
          is_push_nxt = 1'b1;
          cut_nxt     = {1'b0, in_data.timestamp_ticks} - {32'd0, wlen_r};
          case (in_data.mode)
            MODE_PUSH: begin
              if (in_data.interval_us == '0 || in_data.interval_us > MAX_INTERVAL_US)
                state_nxt = ST_FINISH;
              else if (count_r >= cap_r)
                state_nxt = ST_EV_RD;
              else
                state_nxt = ST_PUSH;
            end
            MODE_TRIM: begin
              state_nxt = (wlen_r != '0 && count_r != '0) ? ST_TR_RD : ST_FINISH;
            end
            MODE_QUERY: begin
              state_nxt = (count_r != '0) ? ST_Q_RANK : ST_FINISH;
            end
            default: begin
              oldest_nxt = '0;
              count_nxt  = '0;
              sum_nxt    = '0;
              state_nxt  = ST_FINISH;
            end
          endcase
        end
      end
      ST_EV_RD: begin
        state_nxt = ST_EV_UPD;
      end
      ST_EV_UPD: begin
        sum_nxt    = sum_r - SW'(rd_data.iv);
        oldest_nxt = slot_of(oldest_r, CW'(1));
        count_nxt  = n_m1;
        if (is_push_r ? (n_m1 >= cap_r) : (n_m1 > cap_r))
          state_nxt = ST_EV_RD;
        else
          state_nxt = is_push_r ? ST_PUSH : ST_IDLE;
      end
      ST_PUSH: begin
        wr_en            = 1'b1;
        count_nxt        = count_r + CW'(1);
        sum_nxt          = sum_r + SW'(in_r.interval_us);
        acc_nxt.accepted = 1'b1;
        state_nxt        = ST_FINISH;
      end
      ST_TR_RD: begin
        state_nxt = ST_TR_CHK;
      end
      ST_TR_CHK: begin
        if ($signed({1'b0, rd_data.ts}) < $signed(cut_r)) begin
          sum_nxt    = sum_r - SW'(rd_data.iv);
          oldest_nxt = slot_of(oldest_r, CW'(1));
          count_nxt  = n_m1;
          state_nxt  = (n_m1 != '0) ? ST_TR_RD : ST_FINISH;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_Q_RANK: begin
        prod_nxt  = PW'(q_sat) * PW'(n_m1) + PW'(Q_HALF);
        sel_nxt   = SEL_MEDIAN;
        state_nxt = ST_SEL_INIT;
      end
      ST_SEL_INIT: begin
        res_nxt  = '0;
        mask_nxt = {1'b1, {(IV_W-1){1'b0}}};
        cnt_nxt  = '0;
        idx_nxt  = '0;
        case (sel_r)
          SEL_MEDIAN:   k_nxt = count_r >> 1;
          SEL_QUANTILE: k_nxt = (rank_q >= (CW+2)'(count_r)) ? n_m1 : CW'(rank_q);
          SEL_MIN:      k_nxt = '0;
          default:      k_nxt = n_m1;
        endcase
        state_nxt = ST_SEL_SCAN;
      end
      ST_SEL_SCAN: begin
        rd_addr = slot_of(oldest_r, idx_r);
        if (idx_r != count_r) begin
          idx_nxt = idx_r + CW'(1);
          rv_nxt  = 1'b1;
        end
        if (rv_r && match) cnt_nxt = cnt_r + CW'(1);
        if (idx_r == count_r && !rv_r) state_nxt = ST_SEL_DEC;
      end
      ST_SEL_DEC: begin
        res_nxt = set_res;
        if (!(k_r < cnt_r)) k_nxt = k_r - cnt_r;
        if (mask_r[0]) begin
          case (sel_r)
            SEL_MEDIAN:   acc_nxt.median_us   = set_res;
            SEL_QUANTILE: acc_nxt.quantile_us = set_res;
            SEL_MIN:      acc_nxt.min_us      = set_res;
            default:      acc_nxt.max_us      = set_res;
          endcase
          sel_nxt = sel_r + 2'd1;
          idx_nxt = '0;
          cnt_nxt = '0;
          if (sel_r == SEL_MAX)
            state_nxt = (count_r >= CW'(2)) ? ST_STUT_SCAN : ST_DIV;
          else
            state_nxt = ST_SEL_INIT;
        end else begin
          mask_nxt  = mask_r | (mask_r >> 1);
          cnt_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = ST_SEL_SCAN;
        end
      end
      ST_STUT_SCAN: begin
        rd_addr = slot_of(oldest_r, idx_r);
        if (idx_r != count_r) begin
          idx_nxt = idx_r + CW'(1);
          rv_nxt  = 1'b1;
        end
        if (rv_r && ({1'b0, rd_data.iv} > {acc_r.median_us, 1'b0})) cnt_nxt = cnt_r + CW'(1);
        if (idx_r == count_r && !rv_r) begin
          acc_nxt.stutter_count = FC_W'(cnt_r);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          acc_nxt.average_us = div_quo[IV_W-1:0];
          state_nxt = ST_SPAN_A;
        end
      end
      ST_SPAN_A: begin
        rd_addr   = oldest_r;
        state_nxt = ST_SPAN_B;
      end
      ST_SPAN_B: begin
        rd_addr   = slot_of(oldest_r, n_m1);
        t0_nxt    = rd_data.ts;
        state_nxt = ST_SPAN_C;
      end
      ST_SPAN_C: begin
        if (count_r >= CW'(2) && !diff[63] && diff != '0)
          acc_nxt.span_ticks = diff[TS_W-1:0];
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt             = acc_r;
          out_nxt.frame_count = FC_W'(count_r);
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      cap_r       <= (32'(RESET_CAPACITY) > 32'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH)
                                                              : CW'(RESET_CAPACITY);
      wlen_r      <= '0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      is_push_r   <= 1'b0;
      sel_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      rv_r        <= rv_nxt;
      is_push_r   <= is_push_nxt;
      sel_r       <= sel_nxt;
      if (cfg_wr && paddr[2] == REG_CAPACITY) cap_r <= cap_val;
      if (cfg_wr && paddr[2] == REG_WINDOW) wlen_r <= pwdata;
    end
    in_r   <= in_nxt;
    cut_r  <= cut_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    mask_r <= mask_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    t0_r   <= t0_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (state_r == ST_IDLE && count_r <= cap_r))
    else $error("item accepted while the sequencer was busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(WINDOW_DEPTH))
    else $error("entry count above window depth");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUSH |-> count_r < cap_r)
    else $error("push write without room in the window");
  a_accepted_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && acc_r.accepted) |-> in_r.mode == MODE_PUSH)
    else $error("accepted flag set on a non-push item");
`endif

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench of the frame interval window statistics block.
`timescale 1ns / 1ps
module testbench;
  import fiws_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  fiws_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  fiws_out_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  localparam logic [2:0] ADDR_CAPACITY = 3'd0;
  localparam logic [2:0] ADDR_WINDOW   = 3'd4;

  fiws_entry_t      window_q[$];
  logic [35:0]      window_sum = '0;
  int unsigned      capacity_now = 4096;
  logic [31:0]      window_len_now = '0;
  fiws_out_t        expected_stats[$];
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               errors = 0;
  int               items_sent = 0;
  int               results_seen = 0;
  int               queries_sent = 0;
  longint unsigned  now_ticks = 0;

  frame_interval_window_stats DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic int unsigned rank_at(int unsigned q, int unsigned n);
    longint unsigned r;
    r = (longint'(q) * longint'(n - 1) + 32768) >> 16;
    if (r >= n) r = n - 1;
    return int'(r);
  endfunction

  task automatic evict_oldest();
    if (window_q.size() > 0) begin
      window_sum = window_sum - 36'(window_q[0].iv);
      window_q.delete(0);
    end
  endtask

  task automatic predict_stats(input fiws_in_t item, output fiws_out_t res);
    int unsigned sorted_iv[$];
    int unsigned n, q, med, cnt;
    longint cutoff, span;
    fiws_entry_t entry;
    res = '0;
    case (item.mode)
      MODE_PUSH: begin
        if (item.interval_us != 0 && item.interval_us <= MAX_INTERVAL_US) begin
          while (window_q.size() >= capacity_now) evict_oldest();
          entry.iv = item.interval_us;
          entry.ts = item.timestamp_ticks;
          window_q.insert(window_q.size(), entry);
          window_sum = window_sum + 36'(item.interval_us);
          res.accepted = 1'b1;
        end
      end
      MODE_TRIM: begin
        if (window_len_now != 0) begin
          cutoff = longint'({1'b0, item.timestamp_ticks}) - longint'({32'd0, window_len_now});
          while (window_q.size() > 0 && longint'({1'b0, window_q[0].ts}) < cutoff)
            evict_oldest();
        end
      end
      MODE_QUERY: begin
        n = window_q.size();
        if (n > 0) begin
          q = (item.quantile > Q_ONE) ? 32'(Q_ONE) : 32'(item.quantile);
          foreach (window_q[i]) sorted_iv.insert(sorted_iv.size(), 32'(window_q[i].iv));
          sorted_iv.sort();
          med = sorted_iv[rank_at(32768, n)];
          res.quantile_us = 24'(sorted_iv[rank_at(q, n)]);
          res.median_us   = 24'(med);
          res.min_us      = 24'(sorted_iv[0]);
          res.max_us      = 24'(sorted_iv[n - 1]);
          res.average_us  = 24'(window_sum / n);
          if (n >= 2) begin
            cnt = 0;
            foreach (sorted_iv[i]) if (longint'(sorted_iv[i]) > 2 * longint'(med)) cnt++;
            res.stutter_count = 13'(cnt);
            span = longint'({1'b0, window_q[n - 1].ts}) - longint'({1'b0, window_q[0].ts});
            res.span_ticks = (span > 0) ? 63'(span) : 63'd0;
          end
        end
      end
      default: begin
        window_q.delete();
        window_sum = '0;
      end
    endcase
    res.frame_count = 13'(window_q.size());
  endtask

  task automatic send_item(input fiws_in_t item);
    fiws_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    predict_stats(item, res);
    expected_stats.insert(expected_stats.size(), res);
    items_sent++;
    if (item.mode == MODE_QUERY) queries_sent++;
    @(posedge clk);
  endtask

  task automatic send_mode(input logic [1:0] m, input logic [23:0] iv,
                           input logic [62:0] ts, input logic [16:0] q);
    fiws_in_t item;
    item.mode = m;
    item.interval_us = iv;
    item.timestamp_ticks = ts;
    item.quantile = q;
    send_item(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_CAPACITY) begin
      capacity_now = 32'(value[12:0]);
      if (capacity_now == 0) capacity_now = 1;
      if (capacity_now > 4096) capacity_now = 4096;
      while (window_q.size() > capacity_now) evict_oldest();
    end else begin
      window_len_now = value;
    end
  endtask

  always @(posedge clk) begin
    fiws_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_stats.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
      end else begin
        exp_res = expected_stats[0];
        expected_stats.delete(0);
        if (out_data.accepted !== exp_res.accepted) begin
          $error("accepted: expected %0d actual %0d", exp_res.accepted, out_data.accepted);
          errors++;
        end
        if (out_data.frame_count !== exp_res.frame_count) begin
          $error("frame_count: expected %0d actual %0d",
                 exp_res.frame_count, out_data.frame_count);
          errors++;
        end
        if (out_data.quantile_us !== exp_res.quantile_us) begin
          $error("quantile_us: expected %0d actual %0d",
                 exp_res.quantile_us, out_data.quantile_us);
          errors++;
        end
        if (out_data.median_us !== exp_res.median_us) begin
          $error("median_us: expected %0d actual %0d", exp_res.median_us, out_data.median_us);
          errors++;
        end
        if (out_data.min_us !== exp_res.min_us) begin
          $error("min_us: expected %0d actual %0d", exp_res.min_us, out_data.min_us);
          errors++;
        end
        if (out_data.max_us !== exp_res.max_us) begin
          $error("max_us: expected %0d actual %0d", exp_res.max_us, out_data.max_us);
          errors++;
        end
        if (out_data.average_us !== exp_res.average_us) begin
          $error("average_us: expected %0d actual %0d",
                 exp_res.average_us, out_data.average_us);
          errors++;
        end
        if (out_data.stutter_count !== exp_res.stutter_count) begin
          $error("stutter_count: expected %0d actual %0d",
                 exp_res.stutter_count, out_data.stutter_count);
          errors++;
        end
        if (out_data.span_ticks !== exp_res.span_ticks) begin
          $error("span_ticks: expected %0d actual %0d",
                 exp_res.span_ticks, out_data.span_ticks);
          errors++;
        end
      end
    end
  end

  task automatic test_directed_edges();
    send_mode(MODE_QUERY, 24'd5, 63'd0, 17'd0);
    send_mode(MODE_PUSH, 24'd0, 63'd10, 17'd0);
    send_mode(MODE_PUSH, 24'd16777215, 63'd20, 17'd0);
    send_mode(MODE_PUSH, 24'd10000001, 63'd30, 17'd0);
    send_mode(MODE_PUSH, 24'd1, 63'd0, 17'd0);
    send_mode(MODE_PUSH, 24'd10000000, {63{1'b1}}, 17'd0);
    send_mode(MODE_QUERY, 24'd0, 63'd0, 17'd0);
    send_mode(MODE_QUERY, 24'd0, 63'd0, 17'h10000);
    send_mode(MODE_QUERY, 24'd0, 63'd0, 17'h1FFFF);
    send_mode(MODE_TRIM, 24'd0, {63{1'b1}}, 17'd0);
    send_mode(MODE_CLEAR, 24'hFFFFFF, {63{1'b1}}, 17'h1FFFF);
    send_mode(MODE_PUSH, 24'd100, 63'd500, 17'd0);
    send_mode(MODE_PUSH, 24'd100, 63'd400, 17'd0);
    send_mode(MODE_PUSH, 24'd100, 63'd600, 17'd0);
    send_mode(MODE_PUSH, 24'd500, 63'd700, 17'd0);
    send_mode(MODE_QUERY, 24'd0, 63'd0, 17'd49152);
    send_mode(MODE_PUSH, 24'd200, 63'd100, 17'd0);
    send_mode(MODE_QUERY, 24'd0, 63'd0, 17'd16384);
    send_mode(MODE_CLEAR, 24'd0, 63'd0, 17'd0);
    send_mode(MODE_QUERY, 24'd0, 63'd0, 17'h10000);
  endtask

  task automatic test_capacity_limits();
    int i;
    for (i = 0; i < 6; i++) send_mode(MODE_PUSH, 24'(10 + i), 63'(1000 + 10 * i), 17'd0);
    write_reg(ADDR_CAPACITY, 32'd0);
    send_mode(MODE_QUERY, 24'd0, 63'd0, 17'd32768);
    send_mode(MODE_PUSH, 24'd77, 63'd2000, 17'd0);
    send_mode(MODE_QUERY, 24'd0, 63'd0, 17'd32768);
    write_reg(ADDR_CAPACITY, 32'hFFFF_FFFF);
    for (i = 0; i < 4; i++) send_mode(MODE_PUSH, 24'(30 + i), 63'(3000 + 100 * i), 17'd0);
    write_reg(ADDR_WINDOW, 32'd1);
    send_mode(MODE_TRIM, 24'd0, 63'd3201, 17'd0);
    send_mode(MODE_QUERY, 24'd0, 63'd0, 17'd65535);
    write_reg(ADDR_WINDOW, 32'hFFFF_FFFF);
    send_mode(MODE_TRIM, 24'd0, 63'd5, 17'd0);
    send_mode(MODE_TRIM, 24'hFFFFFF, {63{1'b1}}, 17'd0);
    send_mode(MODE_QUERY, 24'd0, 63'd0, 17'd0);
    write_reg(ADDR_CAPACITY, 32'd3);
  endtask

  function automatic fiws_in_t random_item();
    fiws_in_t item;
    int unsigned pick;
    item = '0;
    item.interval_us = 24'($urandom_range(16777215));
    item.timestamp_ticks = 63'({$urandom, $urandom});
    item.quantile = 17'($urandom_range(131071));
    pick = $urandom_range(99);
    if (pick < 72) begin
      item.mode = MODE_PUSH;
      case ($urandom_range(9))
        0: item.interval_us = $urandom_range(1) ? 24'd0 : 24'($urandom_range(16777215, 10000001));
        1: item.interval_us = 24'($urandom_range(10000000, 9999990));
        default: item.interval_us = 24'($urandom_range(40000, 1));
      endcase
      if ($urandom_range(19) != 0) begin
        now_ticks = now_ticks + $urandom_range(20000);
        item.timestamp_ticks = 63'(now_ticks);
      end
    end else if (pick < 86) begin
      item.mode = MODE_TRIM;
      if ($urandom_range(9) != 0) item.timestamp_ticks = 63'(now_ticks + $urandom_range(30000));
    end else if (pick < 96) begin
      item.mode = MODE_QUERY;
      if ($urandom_range(3) == 0) item.quantile = $urandom_range(1) ? Q_ONE : 17'd0;
      else if ($urandom_range(1)) item.quantile = 17'($urandom_range(65536));
    end else begin
      item.mode = MODE_CLEAR;
    end
    return item;
  endfunction

  task automatic test_random_traffic();
    int p, c, i;
    logic [31:0] caps[5];
    logic [31:0] wins[5];
    caps = '{32'd1, 32'd2, 32'd17, 32'd40, 32'd4096};
    wins = '{32'd0, 32'd100000, 32'hFFFF_FFFF, 32'd0, 32'd60000};
    for (p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 36 : (p == 1) ? 55 : 0;
      stall_pct     = (p == 0) ? 55 : (p == 1) ? 36 : 0;
      for (c = 0; c < 5; c++) begin
        write_reg(ADDR_CAPACITY, caps[(c + p) % 5] | ($urandom_range(1) << 13));
        write_reg(ADDR_WINDOW, wins[(c + 2 * p) % 5]);
        for (i = 0; i < 108; i++) begin
          if (window_q.size() > 60 && $urandom_range(3) == 0)
            send_mode(MODE_CLEAR, 24'd0, 63'd0, 17'd0);
          else
            send_item(random_item());
          if (i == 54 && c == 2) wait_drained();
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_capacity_limits();
    test_random_traffic();
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Covered %0d items (%0d queries), %0d results checked, with capacity and",
             items_sent, queries_sent, results_seen);
    $display("trim window settings at their extremes and three idle and stall mixes.");
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
